[rtl/piq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the positional insert queue.
package piq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_HEAD_RD,
        S_HEAD_OUT
    } t_state;

    localparam int NAME_W   = 64;
    localparam int RATING_W = 16;
    localparam int ENTRY_W  = NAME_W + RATING_W;
    localparam int PRIO_W   = 8;

endpackage

[rtl/positional_insert_queue.sv]
`timescale 1ns / 1ps
// Positional insert queue: circular buffer in one RAM, sequenced insert shift.
// Sequence: push, front insert, pop, no-op and rejected beats pass S_HEAD_RD,
//   then strobe o_valid in S_HEAD_OUT; a mid-queue insert first moves each
//   entry back with an S_SH_RD/S_SH_WR pair, then writes in S_INS_WR.
// Throughput: one beat at a time; busy stays high through the strobe cycle.
// Reset (i_rst_n low, synchronous): queue empty, sequencer idle. RAM is not
//   cleared; only entries below the count are ever reported. No receiver stall.
module positional_insert_queue
    import piq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_operation,
    input  logic [NAME_W-1:0]          i_name_data,
    input  logic [RATING_W-1:0]        i_rating_data,
    input  logic [PRIO_W-1:0]          i_priority_req,
    output logic                       o_valid,
    output logic [NAME_W-1:0]          o_head_name,
    output logic [RATING_W-1:0]        o_head_rating,
    output logic [$clog2(DEPTH+1)-1:0] o_entry_count,
    output logic                       o_is_empty,
    output logic [1:0]                 o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > PRIO_W) ? CW : PRIO_W;
    localparam logic [AW:0]   DEP_A = DEPTH[AW:0];
    localparam logic [CW-1:0] DEP_C = DEPTH[CW-1:0];

    // Sequencer state and queue bookkeeping
    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_idx, n_idx;     // logical slot being filled by shift
    logic [AW-1:0]       r_pos, n_pos;     // logical insert slot
    t_status             r_status, n_status;
    logic [ENTRY_W-1:0]  r_entry, n_entry;

    // RAM port controls
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [ENTRY_W-1:0]  wdata, rdata;

    // Logical to physical mapping: one modular add per port
    logic [AW-1:0]       l_wr, l_rd;
    logic [AW:0]         sum_wr, sum_rd;
    logic [AW-1:0]       phys_wr, phys_rd;
    logic [AW-1:0]       head_dec;
    logic [PW-1:0]       p_ext, c_ext;
    t_op                 op;

    assign sum_wr  = {1'b0, r_head} + {1'b0, l_wr};
    assign sum_rd  = {1'b0, r_head} + {1'b0, l_rd};
    assign phys_wr = (sum_wr >= DEP_A) ? AW'(sum_wr - DEP_A) : sum_wr[AW-1:0];
    assign phys_rd = (sum_rd >= DEP_A) ? AW'(sum_rd - DEP_A) : sum_rd[AW-1:0];
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : AW'(r_head - 1'b1);

    assign p_ext = PW'(i_priority_req);
    assign c_ext = PW'(r_count);
    assign op    = t_op'(i_operation);

    piq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_status <= n_status;
        end
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_entry <= n_entry;
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_status = r_status;
        n_entry  = r_entry;
        we       = 1'b0;
        l_wr     = '0;
        l_rd     = '0;
        waddr    = phys_wr;
        wdata    = r_entry;
        raddr    = phys_rd;
        o_valid  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_entry  = {i_name_data, i_rating_data};
                    n_status = ST_OK;
                    n_state  = S_HEAD_RD;
                    priority case (op)
                        OP_PUSH, OP_INSERT: begin
                            if (r_count >= DEP_C) begin
                                n_status = ST_FULL;
                            end else if (op == OP_PUSH || p_ext > c_ext) begin
                                // tail append
                                l_wr    = r_count[AW-1:0];
                                we      = 1'b1;
                                wdata   = {i_name_data, i_rating_data};
                                n_count = r_count + 1'b1;
                            end else if (p_ext <= PW'(1)) begin
                                // front insert: step head back one slot
                                waddr   = head_dec;
                                we      = 1'b1;
                                wdata   = {i_name_data, i_rating_data};
                                n_head  = head_dec;
                                n_count = r_count + 1'b1;
                            end else begin
                                // mid insert: move tail entries back first
                                n_idx   = r_count[AW-1:0];
                                n_pos   = AW'(p_ext - PW'(1));
                                n_state = S_SH_RD;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_head  = (r_head == AW'(DEPTH - 1)) ? '0
                                                                     : AW'(r_head + 1'b1);
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                l_rd    = AW'(r_idx - 1'b1);
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                l_wr  = r_idx;
                we    = 1'b1;
                wdata = rdata;
                n_idx = AW'(r_idx - 1'b1);
                if (AW'(r_idx - 1'b1) == r_pos) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_INS_WR: begin
                l_wr    = r_pos;
                we      = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                l_rd    = '0;
                n_state = S_HEAD_OUT;
            end
            S_HEAD_OUT: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != S_IDLE);
    assign o_head_name   = (r_count == '0) ? '0 : rdata[ENTRY_W-1:RATING_W];
    assign o_head_rating = (r_count == '0) ? '0 : rdata[RATING_W-1:0];
    assign o_entry_count = r_count;
    assign o_is_empty    = (r_count == '0);
    assign o_status      = r_status;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEP_C)
        else $error("entry count beyond depth");

    a_shift_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> $past(r_state) == S_SH_RD)
        else $error("shift write without preceding read");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == ST_EMPTY) |-> r_count == '0)
        else $error("pop-empty flagged with entries held");

endmodule

[rtl/piq_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module piq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[bench/positional_insert_queue_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the positional insert queue: directed and random beats.
module positional_insert_queue_tb;
    import piq_pkg::*;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int N_RAND  = 1800;

    typedef struct packed {
        logic [NAME_W-1:0]   head_name;
        logic [RATING_W-1:0] head_rating;
        logic [CNT_W-1:0]    entry_count;
        logic                is_empty;
        t_status             status;
    } t_queue_view;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_operation;
    logic [NAME_W-1:0]     i_name_data;
    logic [RATING_W-1:0]   i_rating_data;
    logic [PRIO_W-1:0]     i_priority_req;
    logic                  o_valid;
    logic [NAME_W-1:0]     o_head_name;
    logic [RATING_W-1:0]   o_head_rating;
    logic [CNT_W-1:0]      o_entry_count;
    logic                  o_is_empty;
    logic [1:0]            o_status;

    // shadow copy of the queue contents, head at index 0
    logic [NAME_W-1:0]     shadow_name[$];
    logic [RATING_W-1:0]   shadow_rating[$];
    t_queue_view           pending_views[$];

    int n_errors;
    int n_beats;
    int n_checked;
    int n_full_hits;
    int n_empty_pops;
    int n_mid_inserts;

    positional_insert_queue #(.DEPTH(DEPTH)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_name_data    (i_name_data),
        .i_rating_data  (i_rating_data),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .o_head_name    (o_head_name),
        .o_head_rating  (o_head_rating),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow queue and return the view the block
    // should report afterward.
    function automatic t_queue_view apply_queue_op(t_op op, logic [NAME_W-1:0] nm,
                                                   logic [RATING_W-1:0] rt,
                                                   logic [PRIO_W-1:0] pos);
        t_queue_view v;
        int          cnt;
        v   = '0;
        cnt = shadow_name.size();
        v.status = ST_OK;
        case (op)
            OP_PUSH, OP_INSERT: begin
                if (cnt >= DEPTH) begin
                    v.status = ST_FULL;
                end else if (op == OP_PUSH || pos > cnt) begin
                    shadow_name.push_back(nm);
                    shadow_rating.push_back(rt);
                end else if (pos <= 1) begin
                    // position zero lands at the front as well
                    shadow_name.push_front(nm);
                    shadow_rating.push_front(rt);
                end else begin
                    shadow_name.insert(pos - 1, nm);
                    shadow_rating.insert(pos - 1, rt);
                end
            end
            OP_POP: begin
                if (cnt == 0) begin
                    v.status = ST_EMPTY;
                end else begin
                    void'(shadow_name.pop_front());
                    void'(shadow_rating.pop_front());
                end
            end
            default: ;
        endcase
        cnt = shadow_name.size();
        if (cnt > 0) begin
            v.head_name   = shadow_name[0];
            v.head_rating = shadow_rating[0];
        end
        v.entry_count = CNT_W'(cnt);
        v.is_empty    = (cnt == 0);
        return v;
    endfunction

    // Send one beat: hold start until the block takes it, then work out the
    // expected view. Random gaps go in front, mostly short, now and then long.
    // Start is driven again only after a further clock edge, so the drop of
    // start after the previous beat never shares a time step with the raise.
    task automatic send_op(t_op op, logic [NAME_W-1:0] nm, logic [RATING_W-1:0] rt,
                           logic [PRIO_W-1:0] pos, bit gaps);
        int gap;
        gap = 0;
        if (gaps) begin
            if ($urandom_range(0, 19) == 0) gap = $urandom_range(5, 30);
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
        end
        repeat (gap + 1) @(posedge i_clk);
        start          <= 1'b1;
        i_operation    <= op;
        i_name_data    <= nm;
        i_rating_data  <= rt;
        i_priority_req <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // accepted at this edge
        if (shadow_name.size() >= DEPTH && (op == OP_PUSH || op == OP_INSERT))
            n_full_hits++;
        if (shadow_name.size() == 0 && op == OP_POP) n_empty_pops++;
        if (op == OP_INSERT && pos > 1 && pos <= shadow_name.size()
            && shadow_name.size() < DEPTH)
            n_mid_inserts++;
        pending_views.push_back(apply_queue_op(op, nm, rt, pos));
        n_beats++;
        start <= 1'b0;
    endtask

    // Result checker: every strobe is compared with the oldest expected view.
    always @(posedge i_clk) begin
        t_queue_view want;
        if (i_rst_n && o_valid) begin
            if (pending_views.size() == 0) begin
                $error("result with nothing expected: count %0d status %0d",
                       o_entry_count, o_status);
                n_errors++;
            end else begin
                want = pending_views.pop_front();
                n_checked++;
                if (o_head_name !== want.head_name) begin
                    $error("head_name: expected %h got %h", want.head_name, o_head_name);
                    n_errors++;
                end
                if (o_head_rating !== want.head_rating) begin
                    $error("head_rating: expected %h got %h", want.head_rating,
                           o_head_rating);
                    n_errors++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d got %0d", want.entry_count,
                           o_entry_count);
                    n_errors++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d got %0d", want.is_empty, o_is_empty);
                    n_errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d got %0d", want.status, o_status);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic [NAME_W-1:0] rand_name();
        return {$urandom(), $urandom()};
    endfunction

    // Extremes of every field, every op code, empty pop, front/zero insert,
    // tail insert, insert into empty, and overflow.
    task automatic test_directed();
        int i;
        send_op(OP_POP, '0, '0, '0, 0);                       // pop on empty
        send_op(OP_NOP, '1, '1, '1, 0);                       // no-op reports state
        send_op(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8'd5, 0); // into empty
        send_op(OP_INSERT, 64'h0, 16'h0, 8'd0, 0);            // position zero: front
        send_op(OP_INSERT, 64'h1111, 16'h11, 8'd1, 0);        // position one: front
        send_op(OP_INSERT, 64'h2222, 16'h22, 8'd2, 0);        // middle
        send_op(OP_INSERT, 64'h3333, 16'h33, 8'd255, 0);      // past the tail
        send_op(OP_PUSH, 64'hA5A5_5A5A_A5A5_5A5A, 16'h5AA5, 8'd0, 0);
        for (i = 0; i < 10; i++) send_op(OP_PUSH, rand_name(), 16'($urandom()), '1, 0);
        send_op(OP_PUSH, '1, '1, '0, 0);                      // full: dropped
        send_op(OP_INSERT, '1, '1, 8'd3, 0);                  // full: dropped
        for (i = 0; i < DEPTH + 1; i++) send_op(OP_POP, '0, '0, '0, 0); // drain, extra pop
    endtask

    // Random mix with a push/insert bias redrawn every 150 beats so the queue
    // swings between empty and full; insert positions favor the live range.
    task automatic test_random();
        int   i;
        int   r;
        int   cnt;
        int   bias;
        t_op  op;
        logic [PRIO_W-1:0] pos;
        bias = 50;
        for (i = 0; i < N_RAND; i++) begin
            if (i % 150 == 0) bias = $urandom_range(20, 80);
            cnt = shadow_name.size();
            r   = $urandom_range(0, 99);
            if (r < 3)          op = OP_NOP;
            else if (r < bias)  op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_PUSH;
            else                op = OP_POP;
            case ($urandom_range(0, 5))
                0:       pos = PRIO_W'($urandom());
                1:       pos = PRIO_W'($urandom_range(0, 1));
                default: pos = PRIO_W'($urandom_range(0, cnt + 1));
            endcase
            send_op(op, rand_name(), 16'($urandom()), pos, (i / 200) % 3 != 0);
        end
    endtask

    initial begin
        n_errors = 0;
        n_beats = 0;
        n_checked = 0;
        n_full_hits = 0;
        n_empty_pops = 0;
        n_mid_inserts = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = '0;
        i_name_data    = '0;
        i_rating_data  = '0;
        i_priority_req = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();

        // drain: wait for the last strobe, then wait on for stray ones
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d beats, %0d results checked", n_beats, n_checked);
        $display("full drops %0d, empty pops %0d, mid-queue inserts %0d",
                 n_full_hits, n_empty_pops, n_mid_inserts);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: worst case ~1850 beats, each with its longest gap and shift,
    // at 8 ns a clock is under 1 ms; allow about ten times that.
    initial begin
        #10_000_000;
        $display("timeout waiting for results");
        $display("status: fail");
        $finish;
    end

endmodule
